// ===== rtl/mi3_pkg.sv =====
package mi3_pkg;

   // Port widths of the payload fields.
   localparam int ELEM_W = 16;
   localparam int IDX_W  = 4;
   localparam int ADJ_W  = 33;
   localparam int INV_W  = 49;
   localparam int DET_W  = 49;

   // Matrix geometry.
   localparam int CELLS = 9;
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(CELLS - 1);

   // Matrices that can wait between the loader and the compute engine.
   localparam int QUEUE_DEPTH = 2;

   // Multiplier schedule: two products per cofactor, then three for the determinant.
   localparam int COF_ISSUES = 2 * CELLS;
   localparam int MUL_ISSUES = COF_ISSUES + 3;

   // Divider: magnitude quotient bits and radix-2 steps per clock.
   localparam int QUO_W     = 48;
   localparam int REM_W     = QUO_W + 1;
   localparam int DIV_STEPS = 4;
   localparam int DIV_ITERS = QUO_W / DIV_STEPS;

endpackage

// ===== rtl/mi3_front.sv =====
module mi3_front #(
   parameter int ELEMENT_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [mi3_pkg::ELEM_W-1:0]             element,
   input  logic                                   queue_full,
   output logic                                   push,
   output logic [mi3_pkg::CELLS*ELEMENT_WIDTH-1:0] push_data
);
   import mi3_pkg::*;

   logic [IDX_W-1:0]         load_count_ff, load_count_in;
   logic [ELEMENT_WIDTH-1:0] elem_ff [CELLS-1];
   logic [ELEMENT_WIDTH-1:0] elem_in [CELLS-1];
   logic                     accept;

   // Only the ninth element needs room in the queue.
   assign busy   = (load_count_ff == LAST_POS) && queue_full;
   assign accept = start && !busy;
   assign push   = accept && (load_count_ff == LAST_POS);

   always_comb begin
      for (int i = 0; i < CELLS - 1; i++) begin
         push_data[i*ELEMENT_WIDTH +: ELEMENT_WIDTH] = elem_ff[i];
      end
      push_data[(CELLS-1)*ELEMENT_WIDTH +: ELEMENT_WIDTH] = element[ELEMENT_WIDTH-1:0];
   end

   always_comb begin
      load_count_in = load_count_ff;
      elem_in       = elem_ff;
      if (accept) begin
         for (int i = 0; i < CELLS - 2; i++) begin
            elem_in[i] = elem_ff[i+1];
         end
         elem_in[CELLS-2] = element[ELEMENT_WIDTH-1:0];
         if (load_count_ff == LAST_POS) begin
            load_count_in = '0;
         end else begin
            load_count_in = load_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
      elem_ff <= elem_in;
   end

endmodule

// ===== rtl/mi3_queue.sv =====
module mi3_queue #(
   parameter int WIDTH = 144
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import mi3_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   logic [WIDTH-1:0] store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == FULL_COUNT);
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/mi3_divider.sv =====
module mi3_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [mi3_pkg::INV_W-1:0]  numerator,
   input  logic signed [mi3_pkg::DET_W-1:0]  denominator,
   output logic                              done,
   output logic signed [mi3_pkg::INV_W-1:0]  quotient
);
   import mi3_pkg::*;

   localparam int ITER_W = $clog2(DIV_ITERS);
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(DIV_ITERS - 1);

   logic              running_ff, running_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [QUO_W-1:0]  dvd_ff, dvd_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  dm_ff, dm_in;
   logic              neg_ff, neg_in;
   logic [INV_W-1:0]  quo_ff, quo_in;

   logic [INV_W-1:0]  num_abs;
   logic [DET_W-1:0]  den_abs;
   logic [REM_W-1:0]  r;
   logic [QUO_W-1:0]  d;

   assign done     = done_ff;
   assign quotient = quo_ff;

   assign num_abs = numerator[INV_W-1] ? (~numerator + 1'b1) : numerator;
   assign den_abs = denominator[DET_W-1] ? (~denominator + 1'b1) : denominator;

   // Restoring division on magnitudes, DIV_STEPS quotient bits per clock.
   always_comb begin
      r = rem_ff;
      d = dvd_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         r = {r[REM_W-2:0], d[QUO_W-1]};
         d = {d[QUO_W-2:0], 1'b0};
         if (r >= {1'b0, dm_ff}) begin
            r    = r - {1'b0, dm_ff};
            d[0] = 1'b1;
         end
      end
   end

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      iter_in    = iter_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      dm_in      = dm_ff;
      neg_in     = neg_ff;
      quo_in     = quo_ff;
      if (start) begin
         running_in = 1'b1;
         iter_in    = '0;
         dvd_in     = num_abs[QUO_W-1:0];
         rem_in     = '0;
         dm_in      = den_abs[QUO_W-1:0];
         neg_in     = numerator[INV_W-1] ^ denominator[DET_W-1];
      end else if (running_ff) begin
         dvd_in = d;
         rem_in = r;
         if (iter_ff == LAST_ITER) begin
            running_in = 1'b0;
            done_in    = 1'b1;
            quo_in     = neg_ff ? (~{1'b0, d} + 1'b1) : {1'b0, d};
         end else begin
            iter_in = iter_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      iter_ff <= iter_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dm_ff   <= dm_in;
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
   end

endmodule

// ===== rtl/mi3_back.sv =====
module mi3_back #(
   parameter int ELEMENT_WIDTH = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    queue_empty,
   input  logic [mi3_pkg::CELLS*ELEMENT_WIDTH-1:0] pop_data,
   output logic                                    pop,
   output logic                                    rsp_strobe,
   output logic [mi3_pkg::IDX_W-1:0]               rsp_entry_index,
   output logic signed [mi3_pkg::ADJ_W-1:0]        rsp_adjugate_entry,
   output logic signed [mi3_pkg::INV_W-1:0]        rsp_inverse_entry,
   output logic signed [mi3_pkg::DET_W-1:0]        rsp_determinant,
   output logic                                    rsp_singular,
   output logic                                    rsp_last_entry
);
   import mi3_pkg::*;

   localparam int STEP_W = $clog2(MUL_ISSUES + 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MUL_ISSUES);
   localparam logic [STEP_W-1:0] COF_END   = STEP_W'(COF_ISSUES);

   typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIVSTART, B_DIVWAIT} state_type;

   state_type                state_ff, state_in;
   logic [ELEMENT_WIDTH-1:0] mat_ff [CELLS];
   logic [ELEMENT_WIDTH-1:0] mat_in [CELLS];
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [DET_W-1:0]  prod_ff, prod_in;
   logic [ADJ_W-1:0]         p1_ff, p1_in;
   logic [ADJ_W-1:0]         adj_ff [CELLS];
   logic [ADJ_W-1:0]         adj_in [CELLS];
   logic signed [DET_W-1:0]  det_ff, det_in;
   logic [IDX_W-1:0]         k_ff, k_in;

   logic                     strobe_ff, strobe_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [ADJ_W-1:0]         radj_ff, radj_in;
   logic [INV_W-1:0]         rinv_ff, rinv_in;
   logic [DET_W-1:0]         rdet_ff, rdet_in;
   logic                     rsing_ff, rsing_in;
   logic                     rlast_ff, rlast_in;

   logic signed [ELEM_W-1:0] mul_a;
   logic signed [ELEM_W-1:0] b_narrow;
   logic signed [ADJ_W-1:0]  mul_b;
   logic                     b_from_adj;
   logic [STEP_W-1:0]        tag;
   logic [ADJ_W-1:0]         adj_sel;
   logic signed [INV_W-1:0]  div_num;
   logic                     div_start;
   logic                     div_done;
   logic signed [INV_W-1:0]  div_quotient;
   logic                     singular;

   function automatic logic signed [ELEM_W-1:0] ext(input logic [ELEMENT_WIDTH-1:0] x);
      return ELEM_W'(signed'(x));
   endfunction

   assign rsp_strobe         = strobe_ff;
   assign rsp_entry_index    = idx_ff;
   assign rsp_adjugate_entry = radj_ff;
   assign rsp_inverse_entry  = rinv_ff;
   assign rsp_determinant    = rdet_ff;
   assign rsp_singular       = rsing_ff;
   assign rsp_last_entry     = rlast_ff;

   assign adj_sel  = adj_ff[k_ff];
   assign div_num  = {{(INV_W - ADJ_W){adj_sel[ADJ_W-1]}}, adj_sel} << FRACTION_BITS;
   assign singular = (det_ff == '0);

   // Operand schedule of the shared multiplier. Each adjugate entry takes two
   // products; the last three products expand the determinant along row 0.
   always_comb begin
      mul_a      = '0;
      b_narrow   = '0;
      b_from_adj = 1'b0;
      mul_b      = '0;
      unique case (step_ff)
         5'd0:  begin mul_a = ext(mat_ff[4]); b_narrow = ext(mat_ff[8]); end
         5'd1:  begin mul_a = ext(mat_ff[5]); b_narrow = ext(mat_ff[7]); end
         5'd2:  begin mul_a = ext(mat_ff[7]); b_narrow = ext(mat_ff[2]); end
         5'd3:  begin mul_a = ext(mat_ff[8]); b_narrow = ext(mat_ff[1]); end
         5'd4:  begin mul_a = ext(mat_ff[1]); b_narrow = ext(mat_ff[5]); end
         5'd5:  begin mul_a = ext(mat_ff[2]); b_narrow = ext(mat_ff[4]); end
         5'd6:  begin mul_a = ext(mat_ff[5]); b_narrow = ext(mat_ff[6]); end
         5'd7:  begin mul_a = ext(mat_ff[3]); b_narrow = ext(mat_ff[8]); end
         5'd8:  begin mul_a = ext(mat_ff[8]); b_narrow = ext(mat_ff[0]); end
         5'd9:  begin mul_a = ext(mat_ff[6]); b_narrow = ext(mat_ff[2]); end
         5'd10: begin mul_a = ext(mat_ff[2]); b_narrow = ext(mat_ff[3]); end
         5'd11: begin mul_a = ext(mat_ff[0]); b_narrow = ext(mat_ff[5]); end
         5'd12: begin mul_a = ext(mat_ff[3]); b_narrow = ext(mat_ff[7]); end
         5'd13: begin mul_a = ext(mat_ff[4]); b_narrow = ext(mat_ff[6]); end
         5'd14: begin mul_a = ext(mat_ff[6]); b_narrow = ext(mat_ff[1]); end
         5'd15: begin mul_a = ext(mat_ff[7]); b_narrow = ext(mat_ff[0]); end
         5'd16: begin mul_a = ext(mat_ff[0]); b_narrow = ext(mat_ff[4]); end
         5'd17: begin mul_a = ext(mat_ff[1]); b_narrow = ext(mat_ff[3]); end
         5'd18: begin mul_a = ext(mat_ff[0]); mul_b = adj_ff[0]; b_from_adj = 1'b1; end
         5'd19: begin mul_a = ext(mat_ff[1]); mul_b = adj_ff[3]; b_from_adj = 1'b1; end
         5'd20: begin mul_a = ext(mat_ff[2]); mul_b = adj_ff[6]; b_from_adj = 1'b1; end
         default: begin end
      endcase
      if (!b_from_adj) begin
         mul_b = {{(ADJ_W - ELEM_W){b_narrow[ELEM_W-1]}}, b_narrow};
      end
   end

   always_comb begin
      state_in  = state_ff;
      mat_in    = mat_ff;
      step_in   = step_ff;
      prod_in   = mul_a * mul_b;
      p1_in     = p1_ff;
      adj_in    = adj_ff;
      det_in    = det_ff;
      k_in      = k_ff;
      strobe_in = 1'b0;
      idx_in    = idx_ff;
      radj_in   = radj_ff;
      rinv_in   = rinv_ff;
      rdet_in   = rdet_ff;
      rsing_in  = rsing_ff;
      rlast_in  = rlast_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      tag       = step_ff - 1'b1;
      unique case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               for (int i = 0; i < CELLS; i++) begin
                  mat_in[i] = pop_data[i*ELEMENT_WIDTH +: ELEMENT_WIDTH];
               end
               step_in  = '0;
               det_in   = '0;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            // Product issued in the previous cycle is folded in now.
            if (step_ff != '0) begin
               if (tag < COF_END) begin
                  if (!tag[0]) begin
                     p1_in = prod_ff[ADJ_W-1:0];
                  end else begin
                     adj_in[tag[STEP_W-1:1]] = p1_ff - prod_ff[ADJ_W-1:0];
                  end
               end else begin
                  det_in = det_ff + prod_ff;
               end
            end
            if (step_ff == STEP_LAST) begin
               k_in     = '0;
               state_in = B_DIVSTART;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         B_DIVSTART: begin
            if (singular) begin
               strobe_in = 1'b1;
               idx_in    = k_ff;
               radj_in   = adj_sel;
               rinv_in   = '0;
               rdet_in   = det_ff;
               rsing_in  = 1'b1;
               rlast_in  = (k_ff == LAST_POS);
               if (k_ff == LAST_POS) begin
                  state_in = B_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               div_start = 1'b1;
               state_in  = B_DIVWAIT;
            end
         end
         B_DIVWAIT: begin
            if (div_done) begin
               strobe_in = 1'b1;
               idx_in    = k_ff;
               radj_in   = adj_sel;
               rinv_in   = div_quotient;
               rdet_in   = det_ff;
               rsing_in  = 1'b0;
               rlast_in  = (k_ff == LAST_POS);
               if (k_ff == LAST_POS) begin
                  state_in = B_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = B_DIVSTART;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      mat_ff   <= mat_in;
      step_ff  <= step_in;
      prod_ff  <= prod_in;
      p1_ff    <= p1_in;
      adj_ff   <= adj_in;
      det_ff   <= det_in;
      k_ff     <= k_in;
      idx_ff   <= idx_in;
      radj_ff  <= radj_in;
      rinv_ff  <= rinv_in;
      rdet_ff  <= rdet_in;
      rsing_ff <= rsing_in;
      rlast_ff <= rlast_in;
   end

   mi3_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (det_ff),
      .done        (div_done),
      .quotient    (div_quotient)
   );

endmodule

// ===== rtl/matrix3x3_inverse_core.sv =====
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      req_element (one matrix element)
// response  out        rsp_strobe, one cycle     rsp_entry_index, rsp_adjugate_entry,
//                                                rsp_inverse_entry, rsp_determinant,
//                                                rsp_singular, rsp_last_entry
//
// Elements load in row-major order, one per cycle while busy is low; the ninth beat hands
// the matrix to a two-deep queue, and busy rises only when that beat finds the queue full.
// The engine computes the nine cofactors and the determinant with one shared multiplier,
// then divides each entry in turn in the radix-2 divider (four quotient bits per clock);
// a singular matrix skips the divider and streams its beats with a zero inverse.
// Reset is synchronous and clears loader, queue and sequencer; the receiver cannot stall.
module matrix3x3_inverse_core #(
   parameter int ELEMENT_WIDTH = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [mi3_pkg::ELEM_W-1:0]        req_element,
   output logic                              rsp_strobe,
   output logic [mi3_pkg::IDX_W-1:0]         rsp_entry_index,
   output logic signed [mi3_pkg::ADJ_W-1:0]  rsp_adjugate_entry,
   output logic signed [mi3_pkg::INV_W-1:0]  rsp_inverse_entry,
   output logic signed [mi3_pkg::DET_W-1:0]  rsp_determinant,
   output logic                              rsp_singular,
   output logic                              rsp_last_entry
);
   import mi3_pkg::*;

   localparam int MAT_BITS = CELLS * ELEMENT_WIDTH;

   // Handoff between the loader and the compute engine.
   logic                push;
   logic [MAT_BITS-1:0] push_data;
   logic                queue_full;
   logic                pop;
   logic [MAT_BITS-1:0] pop_data;
   logic                queue_empty;

   // The loader gathers elements and only stalls when a finished matrix has
   // nowhere to go.
   mi3_front #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .element    (req_element),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   mi3_queue #(
      .WIDTH (MAT_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   // The engine takes one matrix at a time and streams its nine result beats.
   mi3_back #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_empty        (queue_empty),
      .pop_data           (pop_data),
      .pop                (pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_adjugate_entry (rsp_adjugate_entry),
      .rsp_inverse_entry  (rsp_inverse_entry),
      .rsp_determinant    (rsp_determinant),
      .rsp_singular       (rsp_singular),
      .rsp_last_entry     (rsp_last_entry)
   );

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mi3_pkg::*;

   // The block runs with its default widths; the checker's arithmetic uses the same ones.
   localparam int FRAC_BITS = 16;
   localparam int DIM       = 3;

   // A generous cycle ceiling; a correct run of 19 matrices plus sender gaps stays well under it.
   localparam int LIMIT     = 100000;

   // Cycles to wait after the last result so that a stray extra beat still gets seen.
   localparam int TAIL      = 200;

   // Sender idle percentages for the random phases. The receiver cannot stall here,
   // so two of the phases run without any idling at all.
   localparam int PHASES     = 4;
   localparam int PER_PHASE  = 4;
   localparam int PHASE_IDLE [PHASES] = '{0, 76, 0, 26};

   // One result beat as seen on the rsp_ ports.
   typedef struct {
      logic [IDX_W-1:0]        entry_index;
      logic signed [ADJ_W-1:0] adjugate_entry;
      logic signed [INV_W-1:0] inverse_entry;
      logic signed [DET_W-1:0] determinant;
      logic                    singular;
      logic                    last_entry;
   } entry_beat_type;

   // A matrix as the stimulus side holds it, row-major, one int per element.
   typedef int matrix_type [CELLS];

   // Shapes of random matrices.
   typedef enum int {
      FILL_FULL,
      FILL_SMALL,
      FILL_CORNER,
      FILL_SINGULAR
   } fill_kind_type;

   // The scoreboard keeps its own copy of the element store and load position.
   // Every accepted element goes through note_element; the ninth one of a matrix
   // produces nine expected beats, which check_result then consumes in order.
   class inverse_scoreboard;
      logic signed [ELEM_W-1:0] store [CELLS];
      int unsigned              load_pos;
      entry_beat_type           awaited [$];
      int unsigned              errors;

      function new();
         load_pos = 0;
         errors   = 0;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      // Element at row r, column c, with indices wrapping around the 3x3 grid.
      function longint elem_at(int unsigned r, int unsigned c);
         return longint'(store[(r % DIM) * DIM + (c % DIM)]);
      endfunction

      // Adjugate entry (i, j) is the cofactor of element (j, i).
      function longint adjugate_at(int unsigned i, int unsigned j);
         return elem_at(j + 1, i + 1) * elem_at(j + 2, i + 2)
              - elem_at(j + 1, i + 2) * elem_at(j + 2, i + 1);
      endfunction

      function void note_element(logic [ELEM_W-1:0] value);
         longint         det;
         longint         adj;
         longint         scale;
         entry_beat_type beat;
         store[load_pos] = value;
         load_pos++;
         if (load_pos < CELLS) begin
            return;
         end
         load_pos = 0;
         scale    = longint'(1) << FRAC_BITS;
         det      = 0;
         for (int k = 0; k < DIM; k++) begin
            det += elem_at(0, k) * adjugate_at(k, 0);
         end
         for (int k = 0; k < CELLS; k++) begin
            adj                 = adjugate_at(k / DIM, k % DIM);
            beat.entry_index    = IDX_W'(k);
            beat.adjugate_entry = ADJ_W'(adj);
            // SystemVerilog integer division truncates toward zero, as the block must.
            beat.inverse_entry  = (det != 0) ? INV_W'((adj * scale) / det) : '0;
            beat.determinant    = DET_W'(det);
            beat.singular       = (det == 0);
            beat.last_entry     = (k == CELLS - 1);
            awaited.push_back(beat);
         end
      endfunction

      function void check_result(entry_beat_type got);
         entry_beat_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("%t: result beat with nothing expected: index %0d adj %0d inv %0d",
                        $realtime, got.entry_index, got.adjugate_entry, got.inverse_entry);
            end
            return;
         end
         want = awaited.pop_front();
         if (got.entry_index !== want.entry_index
             || got.adjugate_entry !== want.adjugate_entry
             || got.inverse_entry !== want.inverse_entry
             || got.determinant !== want.determinant
             || got.singular !== want.singular
             || got.last_entry !== want.last_entry) begin
            errors++;
            if (errors <= 10) begin
               $display("%t: beat differs (index/adj/inv/det/singular/last)", $realtime);
               $display("   expected %0d %0d %0d %0d %b %b", want.entry_index,
                        want.adjugate_entry, want.inverse_entry, want.determinant,
                        want.singular, want.last_entry);
               $display("   actual   %0d %0d %0d %0d %b %b", got.entry_index,
                        got.adjugate_entry, got.inverse_entry, got.determinant,
                        got.singular, got.last_entry);
            end
         end
      endfunction
   endclass

   // All inputs start at known values; reset is held high from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [ELEM_W-1:0] req_element = '0;

   logic                    busy;
   logic                    rsp_strobe;
   logic [IDX_W-1:0]        rsp_entry_index;
   logic signed [ADJ_W-1:0] rsp_adjugate_entry;
   logic signed [INV_W-1:0] rsp_inverse_entry;
   logic signed [DET_W-1:0] rsp_determinant;
   logic                    rsp_singular;
   logic                    rsp_last_entry;

   int unsigned       cycles = 0;
   inverse_scoreboard sb;

   matrix3x3_inverse_core #(
      .ELEMENT_WIDTH(ELEM_W),
      .FRACTION_BITS(FRAC_BITS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_element        (req_element),
      .rsp_strobe         (rsp_strobe),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_adjugate_entry (rsp_adjugate_entry),
      .rsp_inverse_entry  (rsp_inverse_entry),
      .rsp_determinant    (rsp_determinant),
      .rsp_singular       (rsp_singular),
      .rsp_last_entry     (rsp_last_entry)
   );

   always #5 clock = ~clock;

   // The cycle counter is the only watchdog. If the block hangs or drops beats,
   // the run is stopped here and reported as failed.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result beats are sampled right at the rising edge, which sees the values that
   // stood during the cycle just ended. The receiver cannot push back, so every
   // strobed cycle is one beat.
   always @(posedge clock) begin
      entry_beat_type got;
      if (!reset && rsp_strobe) begin
         got.entry_index    = rsp_entry_index;
         got.adjugate_entry = rsp_adjugate_entry;
         got.inverse_entry  = rsp_inverse_entry;
         got.determinant    = rsp_determinant;
         got.singular       = rsp_singular;
         got.last_entry     = rsp_last_entry;
         sb.check_result(got);
      end
   end

   // Drives one element. Before offering it, the sender may sit idle for a random
   // number of cycles with start low. The element is taken at the first edge where
   // start is high and busy is low. On return the caller stands at that edge, and
   // start is still high, so back-to-back elements never drop start in between.
   task automatic send_element(input int value, input int idle_pct);
      while (int'($urandom_range(99)) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_element <= ELEM_W'(value);
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      sb.note_element(ELEM_W'(value));
   endtask

   task automatic send_matrix(input matrix_type m, input int idle_pct);
      for (int k = 0; k < CELLS; k++) begin
         send_element(m[k], idle_pct);
      end
   endtask

   // Drops start and holds off until every expected beat has come back. This is
   // called at the edge that took the last element, so start gets only one update
   // in that step.
   task automatic wait_drained();
      start <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Random matrices come in several shapes. Full-range values exercise every bit
   // of the element port and the widest products. Small values give modest
   // determinants, so the inverse has real fraction bits and truncation matters.
   // Corner values pile up the extremes. Singular matrices get a repeated row or
   // column, which keeps some adjugate entries nonzero while the determinant is zero.
   function automatic matrix_type random_matrix();
      matrix_type    m;
      fill_kind_type kind;
      int            pick;
      int            corners [7];
      corners = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      pick = int'($urandom_range(99));
      if (pick < 40) begin
         kind = FILL_FULL;
      end else if (pick < 65) begin
         kind = FILL_SMALL;
      end else if (pick < 80) begin
         kind = FILL_CORNER;
      end else begin
         kind = FILL_SINGULAR;
      end
      for (int k = 0; k < CELLS; k++) begin
         case (kind)
            FILL_SMALL: begin
               m[k] = int'($urandom_range(14)) - 7;
            end
            FILL_CORNER: begin
               m[k] = corners[$urandom_range(6)];
            end
            default: begin
               m[k] = int'($urandom_range(65535)) - 32768;
            end
         endcase
      end
      if (kind == FILL_SINGULAR) begin
         case ($urandom_range(2))
            0: begin
               for (int c = 0; c < DIM; c++) m[2 * DIM + c] = m[c];
            end
            1: begin
               for (int c = 0; c < DIM; c++) m[2 * DIM + c] = m[DIM + c];
            end
            default: begin
               for (int r = 0; r < DIM; r++) m[r * DIM + 2] = m[r * DIM];
            end
         endcase
      end
      return m;
   endfunction

   initial begin
      matrix_type directed [3];

      sb = new();

      // Extreme elements everywhere, with the largest determinant that the
      // corner values can reach.
      directed[0] = '{-32768, -32768, -32768,
                      -32768,  32767, -32768,
                      -32768, -32768,  32767};
      // Singular: the first two rows are equal, yet the adjugate is not all zero.
      directed[1] = '{ 32767, -32768,  1,
                       32767, -32768,  1,
                           0,      5, -7};
      // A diagonal matrix with a negative pivot; one over minus three must be
      // truncated toward zero in the fraction bits.
      directed[2] = '{ 2,  0, 0,
                       0, -3, 0,
                       0,  0, 1};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The directed matrices go in back to back, then the sender pauses until
      // all of their beats have come back.
      foreach (directed[d]) begin
         send_matrix(directed[d], 0);
      end
      wait_drained();

      // Random phases, each with its own sender idling and each ending in a full
      // drain, so that the queue both fills up and runs dry.
      for (int p = 0; p < PHASES; p++) begin
         for (int n = 0; n < PER_PHASE; n++) begin
            send_matrix(random_matrix(), PHASE_IDLE[p]);
         end
         wait_drained();
      end

      // Give the block time to emit anything it should not.
      repeat (TAIL) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_queue.sv
rtl/mi3_divider.sv
rtl/mi3_back.sv
rtl/matrix3x3_inverse_core.sv
sim/tb_top.sv
